// File: sv/avcfu_pkg.sv
// ----------------------------------------------------------------------------
// avcfu_pkg
// Types and constants for the H.264 FU-A packetiser core.
// ----------------------------------------------------------------------------
package avcfu_pkg;

   localparam logic [7:0]  START_BYTE     = 8'h01;
   localparam logic [7:0]  NRI_F_MASK     = 8'hE0;
   localparam logic [7:0]  NAL_TYPE_MASK  = 8'h1F;
   localparam logic [7:0]  FU_A_TYPE      = 8'd28;
   localparam logic [7:0]  FU_START_BIT   = 8'h80;
   localparam logic [7:0]  FU_END_BIT     = 8'h40;
   localparam logic [15:0] HDR_BYTES      = 16'd2;
   localparam logic [15:0] MAX_LEN_RESET  = 16'd1400;

   localparam logic        KIND_PAYLOAD   = 1'b0;
   localparam logic        KIND_CLOSE     = 1'b1;

   localparam int          HOLD_BYTES     = 3;
   localparam int          QUEUE_DEPTH    = 4;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [7:0] fu_indicator;
      logic [7:0] fu_header;
      logic       nal_end;
      logic       run_last;
   } result_type;

endpackage

// File: sv/avc_fu_a_packetizer_core.sv
// ----------------------------------------------------------------------------
// avc_fu_a_packetizer_core
// Start-code search over a three-byte hold-back window, FU-A fragmentation
// and header generation; results leave through a four-entry output queue.
// ----------------------------------------------------------------------------
// Results are written into the output queue when the byte that causes them is accepted.
// Throughput: one byte per cycle while req_ready is high; a byte that gives a close and a
// payload beat pushes two beats, which leave one at a time through the single result port.
// req_ready is high while the output queue has at least two free entries.
// Reset: synchronous, clears window, packet state and queue; max_len 1400.
module avc_fu_a_packetizer_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_fu_indicator,
   output logic [7:0]  rsp_fu_header,
   output logic        rsp_nal_end,
   output logic        rsp_run_last,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   import avcfu_pkg::*;

   logic [15:0] max_len_ff;
   logic [7:0]  win_ff [HOLD_BYTES];
   logic [7:0]  win_in [HOLD_BYTES];
   logic [1:0]  hold_cnt_ff, hold_cnt_in;
   logic [7:0]  nal_hdr_ff, nal_hdr_in;
   logic        first_ff, first_in;
   logic        open_ff, open_in;
   logic        expect_ff, expect_in;
   logic [15:0] size_ff, size_in;

   result_type  queue_ff [QUEUE_DEPTH];
   logic [1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [2:0]  q_cnt_ff;

   result_type  res0, res1, close_res;
   logic [1:0]  n_res;
   logic [15:0] size_tmp;
   logic        accept, pop, start_code;

   assign req_ready = (q_cnt_ff <= 3'd2);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (q_cnt_ff != 3'd0);
   assign pop       = rsp_valid && rsp_ready;

   assign start_code = (win_ff[0] == 8'h00) && (win_ff[1] == 8'h00) &&
                       (win_ff[2] == 8'h00) && (req_data_byte == START_BYTE);

   always_comb begin
      close_res              = '0;
      close_res.kind         = KIND_CLOSE;
      close_res.fu_indicator = (nal_hdr_ff & NRI_F_MASK) | FU_A_TYPE;
      close_res.fu_header    = (first_ff ? FU_START_BIT : 8'h00) |
                               (nal_hdr_ff & NAL_TYPE_MASK);
   end

   always_comb begin
      win_in      = win_ff;
      hold_cnt_in = hold_cnt_ff;
      nal_hdr_in  = nal_hdr_ff;
      first_in    = first_ff;
      open_in     = open_ff;
      expect_in   = expect_ff;
      size_in     = size_ff;
      size_tmp    = size_ff;
      res0        = '0;
      res1        = '0;
      n_res       = 2'd0;
      if (expect_ff) begin
         nal_hdr_in = req_data_byte;
         expect_in  = 1'b0;
         first_in   = 1'b1;
         open_in    = 1'b1;
         size_in    = HDR_BYTES;
      end else if (hold_cnt_ff == 2'd3) begin
         if (start_code) begin
            if (open_ff) begin
               res0               = close_res;
               res0.fu_header     = close_res.fu_header | FU_END_BIT;
               res0.nal_end       = 1'b1;
               res0.run_last      = 1'b1;
               n_res              = 2'd1;
               first_in           = 1'b0;
            end
            open_in     = 1'b0;
            expect_in   = 1'b1;
            hold_cnt_in = 2'd0;
         end else begin
            if (open_ff) begin
               if (size_ff >= max_len_ff) begin
                  res0              = close_res;
                  first_in          = 1'b0;
                  size_tmp          = HDR_BYTES;
                  res1.kind         = KIND_PAYLOAD;
                  res1.payload_byte = win_ff[0];
                  res1.run_last     = 1'b1;
                  n_res             = 2'd2;
               end else begin
                  res0.kind         = KIND_PAYLOAD;
                  res0.payload_byte = win_ff[0];
                  res0.run_last     = 1'b1;
                  n_res             = 2'd1;
               end
               size_in = size_tmp + 16'd1;
            end
            win_in[0] = win_ff[1];
            win_in[1] = win_ff[2];
            win_in[2] = req_data_byte;
         end
      end else begin
         for (int i = 0; i < HOLD_BYTES; i++) begin
            if (hold_cnt_ff == 2'(i)) begin
               win_in[i] = req_data_byte;
            end
         end
         hold_cnt_in = hold_cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HOLD_BYTES; i++) begin
            win_ff[i] <= 8'h00;
         end
         hold_cnt_ff <= 2'd0;
         nal_hdr_ff  <= 8'h00;
         first_ff    <= 1'b0;
         open_ff     <= 1'b0;
         expect_ff   <= 1'b0;
         size_ff     <= 16'd0;
      end else if (accept) begin
         win_ff      <= win_in;
         hold_cnt_ff <= hold_cnt_in;
         nal_hdr_ff  <= nal_hdr_in;
         first_ff    <= first_in;
         open_ff     <= open_in;
         expect_ff   <= expect_in;
         size_ff     <= size_in;
      end
   end

   // output queue: up to two beats pushed per byte
   always_ff @(posedge clock) begin
      if (accept && (n_res != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (accept && (n_res == 2'd2)) begin
         queue_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         q_cnt_ff  <= 3'd0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + n_res;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 2'd1;
         end
         q_cnt_ff <= q_cnt_ff + (accept ? {1'b0, n_res} : 3'd0) - (pop ? 3'd1 : 3'd0);
      end
   end

   assign rsp_kind         = queue_ff[rd_ptr_ff].kind;
   assign rsp_payload_byte = queue_ff[rd_ptr_ff].payload_byte;
   assign rsp_fu_indicator = queue_ff[rd_ptr_ff].fu_indicator;
   assign rsp_fu_header    = queue_ff[rd_ptr_ff].fu_header;
   assign rsp_nal_end      = queue_ff[rd_ptr_ff].nal_end;
   assign rsp_run_last     = queue_ff[rd_ptr_ff].run_last;

endmodule

// File: sv/avcfu_checker.sv
// ----------------------------------------------------------------------------
// avcfu_checker
// Port-level checks on the packetiser core result channel.
// ----------------------------------------------------------------------------
module avcfu_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_payload_byte,
   input logic [7:0] rsp_fu_indicator,
   input logic [7:0] rsp_fu_header,
   input logic       rsp_nal_end,
   input logic       rsp_run_last
);
   import avcfu_pkg::*;

   // stalled beat holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_payload_byte) && $stable(rsp_fu_header) && $stable(rsp_run_last))
      else $error("stalled result beat changed");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_PAYLOAD) |->
      rsp_fu_indicator == 8'h00 && rsp_fu_header == 8'h00 && !rsp_nal_end &&
      rsp_run_last)
      else $error("payload beat carries header fields");

   a_close_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_CLOSE) |->
      (rsp_fu_indicator & NAL_TYPE_MASK) == FU_A_TYPE && rsp_payload_byte == 8'h00 &&
      rsp_nal_end == rsp_fu_header[6] && (rsp_run_last == rsp_nal_end))
      else $error("malformed close beat");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result offered straight after reset");

endmodule

bind avc_fu_a_packetizer_core avcfu_checker u_avcfu_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_kind         (rsp_kind),
   .rsp_payload_byte (rsp_payload_byte),
   .rsp_fu_indicator (rsp_fu_indicator),
   .rsp_fu_header    (rsp_fu_header),
   .rsp_nal_end      (rsp_nal_end),
   .rsp_run_last     (rsp_run_last)
);
